### rtl/core/fpc_pkg.sv
// Package for the frustum polygon classifier: register indexes, field widths,
// the configuration write bundle, the beat tag and the visibility codes.
// No dependencies.
`default_nettype none

package fpc_pkg;

  localparam int PLANE_FIELD_W  = 16;
  localparam int CFG_DATA_W     = 64;
  localparam int CFG_IDX_W      = 3;
  localparam int NUM_PLANE_REGS = 6;
  localparam int MASK_W         = 6;
  localparam int VIS_W          = 2;

  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_idx_t REG_PLANE_ENABLE = 3'd0;
  localparam cfg_idx_t REG_PLANE0       = 3'd1;

  typedef struct packed {
    logic      we;
    cfg_idx_t  index;
    cfg_data_t data;
  } cfg_wr_t;

  // Side information that rides along with a vertex down the chain.
  typedef struct packed {
    logic [MASK_W-1:0] clip_mask;
    logic              last_vertex;
  } tag_t;

  typedef enum logic [VIS_W-1:0] {
    VIS_OUTSIDE = 2'd0,
    VIS_INSIDE  = 2'd1,
    VIS_PARTIAL = 2'd2
  } vis_t;

endpackage

`default_nettype wire

### rtl/core/fpc_vertex_if.sv
// Vertex channel: valid/ready handshake with one polygon vertex per beat.
// Depends on fpc_pkg.
`default_nettype none

interface fpc_vertex_if #(
  parameter int COORD_BITS = 16
) ();
  logic                              valid;
  logic                              ready;
  logic signed [COORD_BITS-1:0]      pos_x;
  logic signed [COORD_BITS-1:0]      pos_y;
  logic signed [COORD_BITS-1:0]      pos_z;
  logic [fpc_pkg::MASK_W-1:0]        clip_mask;
  logic                              last_vertex;

  modport source (output valid, pos_x, pos_y, pos_z, clip_mask, last_vertex, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, clip_mask, last_vertex, output ready);
endinterface

`default_nettype wire

### rtl/core/fpc_result_if.sv
// Result channel: valid/ready handshake with one visibility code per beat.
// Depends on fpc_pkg.
`default_nettype none

interface fpc_result_if ();
  logic                      valid;
  logic                      ready;
  logic [fpc_pkg::VIS_W-1:0] visibility;

  modport source (output valid, visibility, input ready);
  modport sink   (input valid, visibility, output ready);
endinterface

`default_nettype wire

### rtl/core/frustum_polygon_classifier_unit.sv
// Top level of the frustum polygon classifier: a chain of plane cells feeding
// the flag accumulator. Depends on fpc_pkg, fpc_vertex_if, fpc_result_if,
// fpc_cell and fpc_accum.
//
//   port        direction  beat contents
//   vtx         in         pos_x, pos_y, pos_z, clip_mask, last_vertex
//   res         out        visibility (0 outside, 1 inside, 2 partial)
//   cfg_*       in         register write: index 0 enable, 1..6 planes
//
// One vertex is accepted per cycle while the chain is not stalled; a closing
// vertex passes through each cell's multiply and sum-and-compare stages in turn:
// the accepting edge loads the first of these stages, and the result register
// follows the last cell.
// Reset (rst, synchronous) clears all stage valid bits, the polygon flags,
// the plane registers and the enable register.
// A stalled result port holds back only the closing vertex at the chain end;
// the stages before it keep filling until they are full.
`default_nettype none

module frustum_polygon_classifier_unit #(
  parameter int NUM_PLANES       = 6,
  parameter int COORD_BITS       = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cfg_we,
  input  fpc_pkg::cfg_idx_t   cfg_index,
  input  fpc_pkg::cfg_data_t  cfg_data,
  fpc_vertex_if.sink          vtx,
  fpc_result_if.source        res
);
  import fpc_pkg::*;

  cfg_wr_t cfg;

  logic                    ch_valid  [NUM_PLANES+1];
  logic                    ch_ready  [NUM_PLANES+1];
  logic [3*COORD_BITS-1:0] ch_vtx    [NUM_PLANES+1];
  tag_t                    ch_tag    [NUM_PLANES+1];
  logic [NUM_PLANES-1:0]   ch_behind [NUM_PLANES+1];

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  assign ch_valid[0]           = vtx.valid;
  assign vtx.ready             = ch_ready[0];
  assign ch_vtx[0]             = {vtx.pos_z, vtx.pos_y, vtx.pos_x};
  assign ch_tag[0].clip_mask   = vtx.clip_mask;
  assign ch_tag[0].last_vertex = vtx.last_vertex;
  assign ch_behind[0]          = '0;

  for (genvar i = 0; i < NUM_PLANES; i++) begin : g_cell
    fpc_cell #(
      .NUM_PLANES       (NUM_PLANES),
      .COORD_BITS       (COORD_BITS),
      .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS),
      .PLANE_IDX        (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cfg        (cfg),
      .in_valid   (ch_valid[i]),
      .in_ready   (ch_ready[i]),
      .in_vtx     (ch_vtx[i]),
      .in_tag     (ch_tag[i]),
      .in_behind  (ch_behind[i]),
      .out_valid  (ch_valid[i+1]),
      .out_ready  (ch_ready[i+1]),
      .out_vtx    (ch_vtx[i+1]),
      .out_tag    (ch_tag[i+1]),
      .out_behind (ch_behind[i+1])
    );
  end

  fpc_accum #(
    .NUM_PLANES (NUM_PLANES)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (ch_valid[NUM_PLANES]),
    .in_ready  (ch_ready[NUM_PLANES]),
    .in_tag    (ch_tag[NUM_PLANES]),
    .in_behind (ch_behind[NUM_PLANES]),
    .res       (res)
  );

endmodule

`default_nettype wire

### rtl/core/fpc_cell.sv
// One plane cell of the classifier chain: holds one plane register, multiplies
// the vertex by its normal, then adds, compares and sets its behind bit.
// Depends on fpc_pkg.
`default_nettype none

module fpc_cell #(
  parameter int NUM_PLANES       = 6,
  parameter int COORD_BITS       = 16,
  parameter int NORMAL_FRAC_BITS = 14,
  parameter int PLANE_IDX        = 0
) (
  input  wire                          clk,
  input  wire                          rst,
  input  fpc_pkg::cfg_wr_t             cfg,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [3*COORD_BITS-1:0]      in_vtx,
  input  fpc_pkg::tag_t                in_tag,
  input  wire  [NUM_PLANES-1:0]        in_behind,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [3*COORD_BITS-1:0]      out_vtx,
  output fpc_pkg::tag_t                out_tag,
  output logic [NUM_PLANES-1:0]        out_behind
);
  import fpc_pkg::*;

  localparam int  PROD_W   = COORD_BITS + PLANE_FIELD_W;
  localparam int  OFF_W    = PLANE_FIELD_W + NORMAL_FRAC_BITS;
  localparam int  SUM_W    = (PROD_W > OFF_W) ? PROD_W + 2 : OFF_W + 2;
  localparam bit  WRITABLE = (PLANE_IDX < NUM_PLANE_REGS);

  cfg_data_t plane;
  logic      we_hit;

  logic signed [PLANE_FIELD_W-1:0] nx, ny, nz, off;
  logic signed [COORD_BITS-1:0]    x, y, z;

  // Multiply stage.
  logic                      a_valid;
  logic                      a_ce;
  logic [3*COORD_BITS-1:0]   a_vtx;
  tag_t                      a_tag;
  logic [NUM_PLANES-1:0]     a_behind;
  logic signed [PROD_W-1:0]  a_px, a_py, a_pz;

  // Sum and compare stage.
  logic                      b_ce;
  logic signed [SUM_W-1:0]   off_term;
  logic signed [SUM_W-1:0]   plane_dist;
  logic                      hit;

  assign we_hit = WRITABLE && cfg.we &&
                  (cfg.index == CFG_IDX_W'(int'(REG_PLANE0) + PLANE_IDX));

  always_ff @(posedge clk) begin
    if (rst) begin
      plane <= '0;
    end else if (we_hit) begin
      plane <= cfg.data;
    end
  end

  assign nx  = plane[PLANE_FIELD_W-1:0];
  assign ny  = plane[2*PLANE_FIELD_W-1:PLANE_FIELD_W];
  assign nz  = plane[3*PLANE_FIELD_W-1:2*PLANE_FIELD_W];
  assign off = plane[4*PLANE_FIELD_W-1:3*PLANE_FIELD_W];

  assign x = in_vtx[COORD_BITS-1:0];
  assign y = in_vtx[2*COORD_BITS-1:COORD_BITS];
  assign z = in_vtx[3*COORD_BITS-1:2*COORD_BITS];

  assign b_ce     = !out_valid || out_ready;
  assign a_ce     = !a_valid || b_ce;
  assign in_ready = a_ce;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ce) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ce && in_valid) begin
      a_vtx    <= in_vtx;
      a_tag    <= in_tag;
      a_behind <= in_behind;
      a_px     <= nx * x;
      a_py     <= ny * y;
      a_pz     <= nz * z;
    end
  end

  // A vertex is behind the plane when its distance is zero or negative.
  assign off_term   = SUM_W'(off) <<< NORMAL_FRAC_BITS;
  assign plane_dist = SUM_W'(a_px) + SUM_W'(a_py) + SUM_W'(a_pz) - off_term;
  assign hit        = plane_dist[SUM_W-1] || (plane_dist == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_ce) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ce && a_valid) begin
      out_vtx    <= a_vtx;
      out_tag    <= a_tag;
      out_behind <= a_behind | (NUM_PLANES'(hit) << PLANE_IDX);
    end
  end

endmodule

`default_nettype wire

### rtl/core/fpc_accum.sv
// End of the classifier chain: holds the plane enable register and the
// per-plane polygon flags, and classifies the polygon into the result register.
// Depends on fpc_pkg and fpc_result_if.
`default_nettype none

module fpc_accum #(
  parameter int NUM_PLANES = 6
) (
  input  wire                    clk,
  input  wire                    rst,
  input  fpc_pkg::cfg_wr_t       cfg,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  fpc_pkg::tag_t          in_tag,
  input  wire  [NUM_PLANES-1:0]  in_behind,
  fpc_result_if.source           res
);
  import fpc_pkg::*;

  logic [NUM_PLANES-1:0] plane_enable;
  logic [NUM_PLANES-1:0] en_wr;
  logic [NUM_PLANES-1:0] mask_bits;
  logic [NUM_PLANES-1:0] active;
  logic [NUM_PLANES-1:0] all_behind, all_behind_next;
  logic [NUM_PLANES-1:0] any_behind, any_behind_next;
  logic                  acc;
  logic                  out_valid;
  vis_t                  vis, vis_next;

  for (genvar i = 0; i < NUM_PLANES; i++) begin : g_bit
    if (i < MASK_W) begin : g_used
      assign en_wr[i]     = cfg.data[i];
      assign mask_bits[i] = in_tag.clip_mask[i];
    end else begin : g_unused
      assign en_wr[i]     = 1'b0;
      assign mask_bits[i] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_enable <= '0;
    end else if (cfg.we && cfg.index == REG_PLANE_ENABLE) begin
      plane_enable <= en_wr;
    end
  end

  // Vertices that close no polygon never wait on the result port.
  assign in_ready = !in_tag.last_vertex || !out_valid || res.ready;
  assign acc      = in_valid && in_ready;

  assign all_behind_next = all_behind & in_behind;
  assign any_behind_next = any_behind | in_behind;
  assign active          = plane_enable & mask_bits;

  always_comb begin
    if ((all_behind_next & active) != '0) begin
      vis_next = VIS_OUTSIDE;
    end else if ((any_behind_next & active) != '0) begin
      vis_next = VIS_PARTIAL;
    end else begin
      vis_next = VIS_INSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      all_behind <= '1;
      any_behind <= '0;
    end else if (acc) begin
      if (in_tag.last_vertex) begin
        all_behind <= '1;
        any_behind <= '0;
      end else begin
        all_behind <= all_behind_next;
        any_behind <= any_behind_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc && in_tag.last_vertex) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && in_tag.last_vertex) begin
      vis <= vis_next;
    end
  end

  assign res.valid      = out_valid;
  assign res.visibility = vis;

  a_flags_clear: assert property (@(posedge clk) disable iff (rst)
    acc && in_tag.last_vertex |=> all_behind == '1 && any_behind == '0)
    else $error("polygon flags not cleared after the closing vertex");

  a_flags_nested: assert property (@(posedge clk) disable iff (rst)
    all_behind == '1 || (all_behind & ~any_behind) == '0)
    else $error("a plane has all vertices behind but none recorded behind");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(acc && in_tag.last_vertex))
    else $error("result raised without a closing vertex");

endmodule

`default_nettype wire

### sim/fpc_checker.sv
// Checker for the frustum polygon classifier: watches the register port and both
// channels, predicts the visibility of every closed polygon and compares it.
// Depends on fpc_pkg, fpc_vertex_if and fpc_result_if.
module fpc_checker (
  input  wire                clk,
  input  wire                rst,
  input  wire                cfg_we,
  input  fpc_pkg::cfg_idx_t  cfg_index,
  input  fpc_pkg::cfg_data_t cfg_data,
  fpc_vertex_if              vtx,
  fpc_result_if              res,
  output int                 fail_count,
  output int                 pending_vis
);
  import fpc_pkg::*;

  localparam int FRAC_BITS = 14;

  logic [MASK_W-1:0] plane_on;
  logic [MASK_W-1:0] every_behind;
  logic [MASK_W-1:0] some_behind;
  cfg_data_t         plane_reg [NUM_PLANE_REGS];
  vis_t              vis_expected_q [$];
  int                errors = 0;

  assign fail_count = errors;

  task automatic report_mismatch(string what);
    $display("%0t: visibility check: %s", $time, what);
    errors++;
  endtask

  // One bit per plane, set when the vertex lies on or behind that plane.
  function automatic logic [MASK_W-1:0] planes_behind(logic signed [15:0] x,
                                                      logic signed [15:0] y,
                                                      logic signed [15:0] z);
    logic [MASK_W-1:0] b;
    logic signed [15:0] nx, ny, nz, off;
    longint plane_dist;
    b = '0;
    for (int i = 0; i < NUM_PLANE_REGS; i++) begin
      nx   = plane_reg[i][15:0];
      ny   = plane_reg[i][31:16];
      nz   = plane_reg[i][47:32];
      off  = plane_reg[i][63:48];
      plane_dist = longint'(nx) * longint'(x) + longint'(ny) * longint'(y)
                 + longint'(nz) * longint'(z) - (longint'(off) <<< FRAC_BITS);
      b[i] = (plane_dist <= 0);
    end
    return b;
  endfunction

  always @(posedge clk) begin
    logic [MASK_W-1:0] b;
    logic [MASK_W-1:0] active;
    vis_t want;
    if (rst) begin
      plane_on     = '0;
      every_behind = '1;
      some_behind  = '0;
      for (int i = 0; i < NUM_PLANE_REGS; i++) plane_reg[i] = '0;
      vis_expected_q.delete();
    end else begin
      if (res.valid && res.ready) begin
        if (vis_expected_q.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing expected", res.visibility));
        end else begin
          want = vis_expected_q.pop_front();
          if (res.visibility !== want)
            report_mismatch($sformatf("got %0d, expected %0d (%s)",
                                      res.visibility, want, want.name()));
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_PLANE_ENABLE) begin
          plane_on = cfg_data[MASK_W-1:0];
        end else if (int'(cfg_index) >= int'(REG_PLANE0) &&
                     int'(cfg_index) < int'(REG_PLANE0) + NUM_PLANE_REGS) begin
          plane_reg[int'(cfg_index) - int'(REG_PLANE0)] = cfg_data;
        end
      end
      if (vtx.valid && vtx.ready) begin
        b = planes_behind(vtx.pos_x, vtx.pos_y, vtx.pos_z);
        every_behind &= b;
        some_behind  |= b;
        if (vtx.last_vertex) begin
          // Only the enable register and the mask of the closing beat matter here.
          active = plane_on & vtx.clip_mask;
          if (active == '0) want = VIS_INSIDE;
          else if ((every_behind & active) != '0) want = VIS_OUTSIDE;
          else if ((some_behind & active) != '0) want = VIS_PARTIAL;
          else want = VIS_INSIDE;
          vis_expected_q.push_back(want);
          every_behind = '1;
          some_behind  = '0;
        end
      end
    end
    pending_vis = vis_expected_q.size();
  end

endmodule

### sim/tb_frustum_polygon_classifier_unit.sv
// Testbench top for the frustum polygon classifier: drives polygons and plane
// settings with random stalls on both channels and gives the verdict.
// Depends on fpc_pkg, the channel interfaces, fpc_checker and the block itself.
module tb_frustum_polygon_classifier_unit;
  import fpc_pkg::*;

  localparam int       PIPE_LATENCY = 2 * NUM_PLANE_REGS + 1;
  localparam cfg_idx_t REG_SPARE    = 3'd7;
  localparam int       AXIS_ONE     = 16384;

  logic      clk = 1'b0;
  logic      rst;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_data;
  int        src_idle_pct = 0;
  int        snk_idle_pct = 0;
  int        coord_span = 200;
  int        fail_count;
  int        pending_vis;

  fpc_vertex_if #(.COORD_BITS(16)) vtx_ch ();
  fpc_result_if res_ch ();

  frustum_polygon_classifier_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .vtx       (vtx_ch),
    .res       (res_ch)
  );

  fpc_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .vtx         (vtx_ch),
    .res         (res_ch),
    .fail_count  (fail_count),
    .pending_vis (pending_vis)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    res_ch.ready = ($urandom_range(99) >= snk_idle_pct);
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Holds the sender until every polygon result is out and the plane chain
  // has flushed the open polygon's vertices.
  task automatic settle();
    vtx_ch.valid = 1'b0;
    while (pending_vis != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 4) @(negedge clk);
  endtask

  task automatic send_vertex(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z, logic [MASK_W-1:0] mask,
                             logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      vtx_ch.valid = 1'b0;
      @(negedge clk);
    end
    vtx_ch.valid       = 1'b1;
    vtx_ch.pos_x       = x;
    vtx_ch.pos_y       = y;
    vtx_ch.pos_z       = z;
    vtx_ch.clip_mask   = mask;
    vtx_ch.last_vertex = last;
    @(posedge clk);
    while (!vtx_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [15:0] pick_coord();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return 16'sh0000;
          default: return 16'shFFFF;
        endcase
      end
      1, 2: return 16'($urandom);
      default: return 16'(int'($urandom_range(2 * coord_span)) - coord_span);
    endcase
  endfunction

  // Mostly box-like frusta sized to the current coordinate spread, so that all
  // three outcomes stay common; now and then a plane of raw random bits.
  task automatic random_config();
    logic [15:0]       comp [3];
    logic [MASK_W-1:0] en;
    cfg_data_t         p;
    int                n;
    int                h;
    settle();
    coord_span = $urandom_range(20, 3000);
    case ($urandom_range(5))
      0: en = '0;
      1: en = '1;
      default: en = MASK_W'($urandom_range(63));
    endcase
    write_reg(REG_PLANE_ENABLE, cfg_data_t'(en));
    for (int i = 0; i < NUM_PLANE_REGS; i++) begin
      if ($urandom_range(4) == 0) begin
        p = {$urandom, $urandom};
      end else begin
        for (int k = 0; k < 3; k++)
          comp[k] = ($urandom_range(2) == 0) ? 16'(int'($urandom_range(1023)) - 512) : 16'h0;
        n = $urandom_range(4096, 32767);
        h = $urandom_range(coord_span);
        comp[i / 2] = 16'((i % 2) ? -n : n);
        p = {16'(-h), comp[2], comp[1], comp[0]};
      end
      write_reg(cfg_idx_t'(int'(REG_PLANE0) + i), p);
    end
    if ($urandom_range(1)) write_reg(REG_SPARE, {$urandom, $urandom});
  endtask

  task automatic run_polygons(int n_items, int src_pct, int snk_pct);
    int sent;
    int since_cfg;
    int cfg_every;
    int len;
    logic last;
    logic [MASK_W-1:0] mask;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    sent      = 0;
    since_cfg = 0;
    cfg_every = $urandom_range(60, 200);
    while (sent < n_items) begin
      case ($urandom_range(9))
        0, 1, 2: len = 1;
        8: len = $urandom_range(6, 12);
        default: len = $urandom_range(2, 5);
      endcase
      for (int v = 0; v < len; v++) begin
        // Reconfiguring here often lands in the middle of a polygon.
        if (since_cfg >= cfg_every) begin
          random_config();
          since_cfg = 0;
          cfg_every = $urandom_range(60, 200);
        end
        last = (v == len - 1);
        if (last && $urandom_range(3) != 0) mask = '1;
        else mask = MASK_W'($urandom_range(63));
        send_vertex(pick_coord(), pick_coord(), pick_coord(), mask, last);
        sent++;
        since_cfg++;
      end
    end
  endtask

  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    vtx_ch.valid       = 1'b0;
    vtx_ch.pos_x       = '0;
    vtx_ch.pos_y       = '0;
    vtx_ch.pos_z       = '0;
    vtx_ch.clip_mask   = '0;
    vtx_ch.last_vertex = 1'b0;
    res_ch.ready       = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    src_idle_pct = 10;
    snk_idle_pct = 74;

    // Axis-aligned box: inside is -99..99 on every axis.
    write_reg(REG_PLANE_ENABLE, cfg_data_t'(6'h3F));
    for (int i = 0; i < NUM_PLANE_REGS; i++)
      write_reg(cfg_idx_t'(int'(REG_PLANE0) + i),
                {16'(-100),
                 48'({(i % 2) ? 16'(-AXIS_ONE) : 16'(AXIS_ONE)}) << (16 * (i / 2))});

    send_vertex(0, 0, 0, 6'h3F, 1'b1);
    send_vertex(-200, 0, 0, 6'h3F, 1'b1);
    send_vertex(-200, 0, 0, 6'h3F, 1'b0);
    send_vertex(0, 0, 0, 6'h3F, 1'b0);
    send_vertex(50, 50, 50, 6'h3F, 1'b1);
    send_vertex(16'sh8000, 0, 0, 6'h00, 1'b0);
    send_vertex(-100, 5, 5, 6'h15, 1'b0);
    send_vertex(-150, 16'sh8000, 16'sh7FFF, 6'h3F, 1'b1);
    send_vertex(-200, 0, 0, 6'h00, 1'b1);
    send_vertex(-200, 0, 0, 6'h3E, 1'b1);
    send_vertex(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 6'h3F, 1'b1);
    send_vertex(16'sh8000, 16'sh8000, 16'sh8000, 6'h3F, 1'b1);
    send_vertex(99, -99, 99, 6'h2A, 1'b1);

    // Plane and enable changes while a polygon is open; the spare index is a no-op.
    send_vertex(-200, 0, 0, 6'h3F, 1'b0);
    settle();
    write_reg(REG_PLANE0, '0);
    write_reg(REG_SPARE, '1);
    send_vertex(0, 0, 0, 6'h01, 1'b1);
    send_vertex(0, 0, 0, 6'h3F, 1'b0);
    settle();
    write_reg(REG_PLANE_ENABLE, '0);
    send_vertex(5, 5, 5, 6'h3F, 1'b1);

    // Extreme plane fields; planes four and five stay all zero.
    settle();
    write_reg(REG_PLANE_ENABLE, cfg_data_t'(6'h3F));
    write_reg(REG_PLANE0, 64'h7FFF_7FFF_7FFF_7FFF);
    write_reg(REG_PLANE0 + 3'd1, 64'h8000_8000_8000_8000);
    write_reg(REG_PLANE0 + 3'd2, 64'h7FFF_8000_8000_8000);
    write_reg(REG_PLANE0 + 3'd3, 64'h8000_7FFF_7FFF_7FFF);
    write_reg(REG_PLANE0 + 3'd4, '0);
    write_reg(REG_PLANE0 + 3'd5, '0);
    send_vertex(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 6'h0F, 1'b1);
    send_vertex(16'sh8000, 16'sh8000, 16'sh8000, 6'h0F, 1'b1);
    send_vertex(16'sh7FFF, 16'sh8000, 0, 6'h0F, 1'b0);
    send_vertex(-1, -1, -1, 6'h0F, 1'b1);
    send_vertex(0, 0, 0, 6'h30, 1'b1);

    random_config();
    run_polygons(550, 10, 74);
    run_polygons(550, 74, 10);
    run_polygons(550, 0, 0);

    vtx_ch.valid = 1'b0;
    for (int w = 0; w < 100000 && pending_vis != 0; w++) @(negedge clk);
    repeat (PIPE_LATENCY + 4) @(negedge clk);
    if (fail_count == 0 && pending_vis == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

### files.f
rtl/core/fpc_pkg.sv
rtl/core/fpc_vertex_if.sv
rtl/core/fpc_result_if.sv
rtl/core/fpc_cell.sv
rtl/core/fpc_accum.sv
rtl/core/frustum_polygon_classifier_unit.sv
sim/fpc_checker.sv
sim/tb_frustum_polygon_classifier_unit.sv
